### rtl/dqis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqis_pkg: shared types and constants
// Window register layout, reset values and stream word widths of the
// debounced quadrature input selector.
// ----------------------------------------------------------------------------
package dqis_pkg;

    // APB register file geometry
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_TILT_WINDOW    = 2'd0,
        REG_ENCODER_WINDOW = 2'd1,
        REG_BUTTON_WINDOW  = 2'd2
    } reg_idx_t;

    // Window register reset values in microseconds
    localparam logic [31:0] TILT_WINDOW_RST    = 32'd50000;
    localparam logic [31:0] ENCODER_WINDOW_RST = 32'd1000;
    localparam logic [31:0] BUTTON_WINDOW_RST  = 32'd100000;

    // Stream word widths (fields packed, zero-filled to whole bytes)
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;

    // Sampling windows handed from the register file to the datapath
    typedef struct packed {
        logic [31:0] tilt_window_us;
        logic [31:0] encoder_window_us;
        logic [31:0] button_window_us;
    } cfg_t;

    // Application index codes
    typedef enum logic [1:0] {
        APP_0 = 2'd0,
        APP_1 = 2'd1,
        APP_2 = 2'd2
    } app_t;

endpackage : dqis_pkg
`default_nettype wire

### rtl/dqis_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqis_regs: window register file
// APB-style write/read access to the three sampling window registers.
// ----------------------------------------------------------------------------
module dqis_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dqis_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dqis_pkg::DATA_W-1:0]   pwdata,
    output logic      [dqis_pkg::DATA_W-1:0]   prdata,
    output dqis_pkg::cfg_t                     cfg
);
    import dqis_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign idx   = paddr[3:2];
    assign wr_en = psel && penable && pwrite;

    // Register writes; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tilt_window_us    <= TILT_WINDOW_RST;
            cfg_reg.encoder_window_us <= ENCODER_WINDOW_RST;
            cfg_reg.button_window_us  <= BUTTON_WINDOW_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TILT_WINDOW:    cfg_reg.tilt_window_us    <= pwdata;
                REG_ENCODER_WINDOW: cfg_reg.encoder_window_us <= pwdata;
                REG_BUTTON_WINDOW:  cfg_reg.button_window_us  <= pwdata;
                default:            ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_TILT_WINDOW:    prdata = cfg_reg.tilt_window_us;
            REG_ENCODER_WINDOW: prdata = cfg_reg.encoder_window_us;
            REG_BUTTON_WINDOW:  prdata = cfg_reg.button_window_us;
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule : dqis_regs
`default_nettype wire

### rtl/debounced_quadrature_input_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_quadrature_input_selector: encoder, button and tilt qualifier
// Windowed sampling of encoder phases, button and tilt pins per poll word,
// with position count, click pulse and app index stepping.
// ----------------------------------------------------------------------------
//  channel   | dir | fields (lsb first)
//  ----------+-----+-------------------------------------------------------
//  s_axis    | in  | now_us[31:0] phase_a phase_b button_level tilt_level
//  m_axis    | out | tilt_horizontal position[31:0] app_index[1:0] click
//  apb       | in  | 0x0 tilt_window_us 0x4 encoder_window_us 0x8 button
//
//  One word per clock sustained while m_tready is high; a word taken into
//  the input register reaches m_axis through the state/result register,
//  which loads from the input register when the output is free.
//  All state updates are computed in the step logic between the
//  input register and the result register.
//  A stalled output holds the result register; the input register takes
//  one more word and then s_tready drops. s_tready stays high while
//  m_tready is.
//  Reset clears state to idle pins, zero count and app 0.
// ----------------------------------------------------------------------------
module debounced_quadrature_input_selector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // now_us[31:0], phase_a[32], phase_b[33], button_level[34], tilt_level[35]
    input  wire logic [dqis_pkg::IN_TDATA_W-1:0]   s_tdata,
    // master stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tilt_horizontal[0], position[32:1], app_index[34:33], click[35]
    output logic      [dqis_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dqis_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [dqis_pkg::DATA_W-1:0]       pwdata,
    output logic      [dqis_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready
);
    import dqis_pkg::*;

    cfg_t cfg;

    dqis_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Input register
    logic        in_valid_reg;
    logic [31:0] in_now_reg;
    logic        in_a_reg;
    logic        in_b_reg;
    logic        in_btn_reg;
    logic        in_tilt_reg;

    // Sampling state
    logic [31:0] tilt_time_reg;
    logic [31:0] enc_time_reg;
    logic [31:0] btn_time_reg;
    logic        prev_a_reg;
    logic        prev_b_reg;
    logic        prev_btn_reg;
    logic        tilt_state_reg;
    logic [31:0] count_reg;
    app_t        app_sel_reg;

    // Result register
    logic        out_valid_reg;
    logic        click_reg;

    logic        out_free;
    logic        advance;
    logic        s_fire;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_now_reg  <= s_tdata[31:0];
            in_a_reg    <= s_tdata[32];
            in_b_reg    <= s_tdata[33];
            in_btn_reg  <= s_tdata[34];
            in_tilt_reg <= s_tdata[35];
        end
    end

    // Step logic: window checks
    logic        tilt_due;
    logic        enc_due;
    logic        btn_due;
    logic [31:0] tilt_elapsed;
    logic [31:0] enc_elapsed;
    logic [31:0] btn_elapsed;

    assign tilt_elapsed = in_now_reg - tilt_time_reg;
    assign enc_elapsed  = in_now_reg - enc_time_reg;
    assign btn_elapsed  = in_now_reg - btn_time_reg;
    assign tilt_due     = tilt_elapsed > cfg.tilt_window_us;
    assign enc_due      = enc_elapsed  > cfg.encoder_window_us;
    assign btn_due      = btn_elapsed  > cfg.button_window_us;

    // Step logic: rising-edge counting, direction from the other phase
    logic       a_rise;
    logic       b_rise;
    logic [1:0] up;
    logic [1:0] down;
    logic       step_up;
    logic       step_down;
    logic [31:0] count_next;
    app_t        app_next;
    logic        click_next;

    assign a_rise = enc_due && in_a_reg && !prev_a_reg;
    assign b_rise = enc_due && in_b_reg && !prev_b_reg;
    assign up     = {1'b0, a_rise && !in_b_reg} + {1'b0, b_rise && in_a_reg};
    assign down   = {1'b0, a_rise && in_b_reg}  + {1'b0, b_rise && !in_a_reg};
    assign step_up    = up > down;
    assign step_down  = down > up;
    assign count_next = count_reg + {30'd0, up} - {30'd0, down};
    assign click_next = btn_due && !in_btn_reg && prev_btn_reg;

    // App index stepping, modulo 3
    always_comb
    begin
        app_next = app_sel_reg;
        if (step_up)
        begin
            case (app_sel_reg)
                APP_0:   app_next = APP_1;
                APP_1:   app_next = APP_2;
                default: app_next = APP_0;
            endcase
        end
        else if (step_down)
        begin
            case (app_sel_reg)
                APP_0:   app_next = APP_2;
                APP_1:   app_next = APP_0;
                default: app_next = APP_1;
            endcase
        end
    end

    // State and result register, loaded together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_time_reg  <= '0;
            enc_time_reg   <= '0;
            btn_time_reg   <= '0;
            prev_a_reg     <= 1'b1;
            prev_b_reg     <= 1'b1;
            prev_btn_reg   <= 1'b1;
            tilt_state_reg <= 1'b0;
            count_reg      <= '0;
            app_sel_reg    <= APP_0;
            out_valid_reg  <= 1'b0;
            click_reg      <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                if (tilt_due)
                begin
                    tilt_state_reg <= !in_tilt_reg;
                    tilt_time_reg  <= in_now_reg;
                end
                if (enc_due)
                begin
                    prev_a_reg   <= in_a_reg;
                    prev_b_reg   <= in_b_reg;
                    enc_time_reg <= in_now_reg;
                end
                if (btn_due)
                begin
                    prev_btn_reg <= in_btn_reg;
                    btn_time_reg <= in_now_reg;
                end
                count_reg   <= count_next;
                app_sel_reg <= app_next;
                click_reg   <= click_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, click_reg, app_sel_reg, count_reg, tilt_state_reg};

endmodule : debounced_quadrature_input_selector
`default_nettype wire

### rtl/dqis_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dqis_checker: port-level checks
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module dqis_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [dqis_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import dqis_pkg::*;

    logic        m_fire;
    logic        seen_reg;
    logic [31:0] last_pos_reg;
    logic [1:0]  last_app_reg;

    assign m_fire = m_tvalid && m_tready;

    // Track the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_pos_reg <= '0;
            last_app_reg <= '0;
        end
        else if (m_fire)
        begin
            seen_reg     <= 1'b1;
            last_pos_reg <= m_tdata[32:1];
            last_app_reg <= m_tdata[34:33];
        end
    end

    // App index stays within 0..2
    a_app_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:33] != 2'd3))
        else $error("app_index out of range");

    // App index moves exactly when the position moves
    a_app_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && seen_reg) |->
            ((m_tdata[32:1] != last_pos_reg) == (m_tdata[34:33] != last_app_reg)))
        else $error("app_index and position disagree");

    // Input side never blocks while the output side drains
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // A stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word changed under stall");

endmodule : dqis_checker

bind debounced_quadrature_input_selector dqis_checker u_dqis_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for debounced_quadrature_input_selector
// Drives poll words on s_axis in bursts and watches m_axis under a changing
// backpressure pattern. An in-bench model of the three sampling windows,
// the quadrature counter, the click detector and the app stepping predicts
// every output word. The window registers are changed between phases over
// APB, with read-back, and each phase runs directed or randomized polls.
// ----------------------------------------------------------------------------
module tb_top;
    import dqis_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 6;
    // address decoded as register index three, which the block must ignore
    localparam logic [ADDR_W-1:0] UNUSED_ADDR = 4'hC;

    // one predicted output word
    typedef struct {
        logic        tilt_h;
        logic [31:0] position;
        app_t        app;
        logic        click;
    } selector_out_t;

    // DUT connections, all at known values from time zero
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // now_us[31:0], phase_a[32], phase_b[33], button_level[34], tilt_level[35]
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // tilt_horizontal[0], position[32:1], app_index[34:33], click[35]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [DATA_W-1:0]      pwdata   = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // model state
    cfg_t        win;
    logic [31:0] tilt_stamp;
    logic [31:0] enc_stamp;
    logic [31:0] btn_stamp;
    logic        last_a;
    logic        last_b;
    logic        last_btn;
    logic        tilt_horiz;
    logic [31:0] pos_count;
    app_t        app_sel;

    selector_out_t expected_q[$];
    int unsigned   mismatch_count = 0;

    // stimulus state
    int          burst_left = 0;
    logic [31:0] poll_time  = '0;
    int          quad_phase = 0;
    logic        btn_pin    = 1'b1;
    logic        tilt_pin   = 1'b1;

    // receiver stall pattern state
    int          ready_mode = 0;
    int          mode_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_cycles = 0;

    debounced_quadrature_input_selector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    task automatic reset_selector_model();
        win.tilt_window_us    = TILT_WINDOW_RST;
        win.encoder_window_us = ENCODER_WINDOW_RST;
        win.button_window_us  = BUTTON_WINDOW_RST;
        tilt_stamp = '0;
        enc_stamp  = '0;
        btn_stamp  = '0;
        last_a     = 1'b1;
        last_b     = 1'b1;
        last_btn   = 1'b1;
        tilt_horiz = 1'b0;
        pos_count  = '0;
        app_sel    = APP_0;
    endtask

    // advance the model by one poll and queue the word it should produce
    task automatic advance_selector(input logic [31:0] now, input logic a, input logic b,
                                    input logic btn, input logic tilt);
        logic [31:0]   elapsed;
        int            up;
        int            down;
        selector_out_t word;
        up = 0;
        down = 0;
        word.click = 1'b0;

        elapsed = now - tilt_stamp;
        if (elapsed > win.tilt_window_us)
        begin
            tilt_horiz = ~tilt;
            tilt_stamp = now;
        end

        // rising edges only; direction from the other phase's current level
        elapsed = now - enc_stamp;
        if (elapsed > win.encoder_window_us)
        begin
            if (a && !last_a)
            begin
                if (b) down++;
                else   up++;
            end
            if (b && !last_b)
            begin
                if (a) up++;
                else   down++;
            end
            last_a = a;
            last_b = b;
            enc_stamp = now;
        end

        elapsed = now - btn_stamp;
        if (elapsed > win.button_window_us)
        begin
            word.click = last_btn && !btn;
            last_btn = btn;
            btn_stamp = now;
        end

        pos_count = pos_count + 32'(up) - 32'(down);
        if (up > down)
            app_sel = app_t'((int'(app_sel) + 1) % 3);
        else if (down > up)
            app_sel = app_t'((int'(app_sel) + 2) % 3);

        word.tilt_h   = tilt_horiz;
        word.position = pos_count;
        word.app      = app_sel;
        expected_q.push_back(word);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected 0x%08h actual 0x%08h", what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Output word checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_word
        selector_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected word", 32'h0, m_tdata[31:0]);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[0] !== want.tilt_h)
                    report_mismatch("tilt_horizontal", 32'(want.tilt_h), 32'(m_tdata[0]));
                if (m_tdata[32:1] !== want.position)
                    report_mismatch("position", want.position, m_tdata[32:1]);
                if (m_tdata[34:33] !== want.app)
                    report_mismatch("app_index", 32'(want.app), 32'(m_tdata[34:33]));
                if (m_tdata[35] !== want.click)
                    report_mismatch("click", 32'(want.click), 32'(m_tdata[35]));
            end
        end
    end

    // receiver: a backpressure mode drawn at random from four, redrawn when its countdown runs out
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (cycle_count % 5 != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stream sender
    // ------------------------------------------------------------------
    task automatic send_word(input logic [31:0] now, input logic a, input logic b,
                             input logic btn, input logic tilt);
        int gap;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, tilt, btn, b, a, now};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        advance_selector(now, a, b, btn, tilt);
        burst_left--;
    endtask

    // stop sending and wait until every predicted word has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // program all three windows, poke the unused slot, then read back
    task automatic set_windows(input logic [31:0] tilt_w, input logic [31:0] enc_w,
                               input logic [31:0] btn_w);
        logic [31:0] rd;
        logic [31:0] want;
        wait_idle();
        apb_write({REG_TILT_WINDOW, 2'b00}, tilt_w);
        win.tilt_window_us = tilt_w;
        apb_write({REG_ENCODER_WINDOW, 2'b00}, enc_w);
        win.encoder_window_us = enc_w;
        apb_write({REG_BUTTON_WINDOW, 2'b00}, btn_w);
        win.button_window_us = btn_w;
        apb_write(UNUSED_ADDR, $urandom);
        for (int i = 0; i < 3; i++)
        begin
            apb_read({reg_idx_t'(i), 2'b00}, rd);
            want = (reg_idx_t'(i) == REG_TILT_WINDOW)    ? win.tilt_window_us :
                   (reg_idx_t'(i) == REG_ENCODER_WINDOW) ? win.encoder_window_us :
                                                           win.button_window_us;
            if (rd !== want)
                report_mismatch("window readback", want, rd);
        end
    endtask

    // ------------------------------------------------------------------
    // Random polls: timestamps step near the window thresholds, the
    // encoder mostly walks the Gray sequence, with some pin noise
    // ------------------------------------------------------------------
    task automatic random_items(input int n);
        logic [31:0]     w;
        logic [31:0]     delta;
        longint unsigned span;
        int              pick;
        logic            a;
        logic            b;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 2);
            w = (pick == 0) ? win.tilt_window_us :
                (pick == 1) ? win.encoder_window_us : win.button_window_us;
            span = 64'(w) * 2 + 4;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            case ($urandom_range(0, 9))
                0:       delta = '0;
                1, 2, 3: delta = w + $urandom_range(0, 2);
                4, 5, 6: delta = $urandom_range(0, 32'(span));
                7:       delta = $urandom;
                default: delta = $urandom_range(1, 8);
            endcase
            poll_time = poll_time + delta;

            pick = $urandom_range(0, 19);
            if (pick < 3)
            begin
                a = $urandom_range(0, 1);
                b = $urandom_range(0, 1);
                quad_phase = a ? (b ? 2 : 1) : (b ? 3 : 0);
            end
            else
            begin
                if (pick < 11)
                    quad_phase = (quad_phase + 1) % 4;
                else if (pick < 17)
                    quad_phase = (quad_phase + 3) % 4;
                a = (quad_phase == 1) || (quad_phase == 2);
                b = (quad_phase == 2) || (quad_phase == 3);
            end
            if ($urandom_range(0, 4) == 0)
                btn_pin = ~btn_pin;
            if ($urandom_range(0, 9) == 0)
                tilt_pin = ~tilt_pin;
            send_word(poll_time, a, b, btn_pin, tilt_pin);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset windows: threshold, wrap, each edge rule and the click
    task automatic test_directed_edges();
        send_word(32'd0,          1'b1, 1'b1, 1'b1, 1'b1); // zero elapsed, nothing sampled
        send_word(32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0); // all groups, falls, click
        send_word(32'd999,        1'b1, 1'b0, 1'b1, 1'b0); // elapsed equals window
        send_word(32'd1000,       1'b1, 1'b0, 1'b1, 1'b0); // A up, B low: count up
        send_word(32'd2001,       1'b1, 1'b1, 1'b1, 1'b0); // B up, A high: count up
        send_word(32'd3002,       1'b0, 1'b1, 1'b1, 1'b0); // A falls
        send_word(32'd4003,       1'b0, 1'b0, 1'b1, 1'b0); // B falls
        send_word(32'd5004,       1'b0, 1'b1, 1'b1, 1'b0); // B up, A low: count down
        send_word(32'd6005,       1'b1, 1'b1, 1'b1, 1'b0); // A up, B high: count down
        send_word(32'd7006,       1'b0, 1'b0, 1'b1, 1'b0);
        send_word(32'd8007,       1'b1, 1'b1, 1'b1, 1'b0); // both rise: no net change
        send_word(32'd50000,      1'b1, 1'b1, 1'b1, 1'b1); // tilt resampled, vertical
        send_word(32'd99999,      1'b1, 1'b1, 1'b1, 1'b1); // button still blocked
        send_word(32'd100000,     1'b1, 1'b1, 1'b1, 1'b1); // button released
        send_word(32'd200001,     1'b1, 1'b1, 1'b0, 1'b1); // press: click
        send_word(32'd200002,     1'b1, 1'b1, 1'b1, 1'b1); // inside window: no click
        send_word(32'h8000_0000,  1'b0, 1'b1, 1'b0, 1'b1); // held press, no click
        send_word(32'hFFFF_FFFE,  1'b1, 1'b1, 1'b1, 1'b0);
        poll_time = 32'hFFFF_FFFE;
    endtask

    task automatic test_default_windows();
        random_items(300);
    endtask

    // window of zero: every new timestamp samples every group
    task automatic test_zero_windows();
        set_windows(32'd0, 32'd0, 32'd0);
        random_items(300);
    endtask

    // largest window: nothing can ever be sampled
    task automatic test_closed_windows();
        set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_items(150);
    endtask

    task automatic test_short_windows();
        set_windows($urandom_range(1, 50), $urandom_range(1, 50), $urandom_range(1, 50));
        random_items(400);
    endtask

    task automatic test_mixed_windows();
        set_windows(32'd0, 32'hFFFF_FFFF, $urandom_range(0, 3000));
        random_items(200);
        set_windows($urandom_range(0, 3000), $urandom_range(0, 20), 32'd0);
        random_items(200);
    endtask

    task automatic test_restored_defaults();
        set_windows(TILT_WINDOW_RST, ENCODER_WINDOW_RST, BUTTON_WINDOW_RST);
        random_items(400);
    endtask

    initial
    begin
        reset_selector_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_default_windows();
        test_zero_windows();
        test_closed_windows();
        test_short_windows();
        test_mixed_windows();
        test_restored_defaults();

        wait_idle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
rtl/dqis_pkg.sv
rtl/dqis_regs.sv
rtl/debounced_quadrature_input_selector.sv
rtl/dqis_checker.sv
dv/tb_top.sv
